/* rtl/ncp_pkg.sv */
// shared types, constants and decode functions for the note and chord command parser
// no dependencies

package ncp_pkg;

  localparam int unsigned MaxText   = 4;
  localparam int unsigned LenWidth  = 3;
  localparam int unsigned PitchWidth = 7;

  localparam logic [7:0] ChChord = 8'h21;  // '!'
  localparam logic [7:0] ChSharp = 8'h23;  // '#'
  localparam logic [7:0] ChFlat  = 8'h62;  // 'b'
  localparam logic [7:0] ChZero  = 8'h30;  // '0'
  localparam logic [7:0] ChNine  = 8'h39;  // '9'
  localparam logic [7:0] ChSev   = 8'h37;  // '7'
  localparam logic [7:0] ChFive  = 8'h35;  // '5'
  localparam logic [7:0] ChMin   = 8'h6d;  // 'm'
  localparam logic [7:0] ChDim   = 8'h6f;  // 'o'

  typedef enum logic [1:0] {
    StNote  = 2'd0,
    StChord = 2'd1,
    StError = 2'd2,
    StBelow = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KindSeventh = 2'd0,
    KindMajor   = 2'd1,
    KindMinor   = 2'd2,
    KindDim     = 2'd3
  } kind_e;

  // parsed command waiting to be sent out
  typedef struct packed {
    logic                    err;
    logic                    chord;
    kind_e                   kind;
    logic [PitchWidth-1:0]   base;
  } cmd_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] cls;
  } cls_t;

  function automatic cls_t letter_class(input logic [7:0] c);
    cls_t r;
    r.ok = 1'b1;
    case (c)
      8'h41:   r.cls = 4'd0;
      8'h42:   r.cls = 4'd2;
      8'h43:   r.cls = 4'd3;
      8'h44:   r.cls = 4'd5;
      8'h45:   r.cls = 4'd7;
      8'h46:   r.cls = 4'd8;
      8'h47:   r.cls = 4'd10;
      default: begin
        r.ok  = 1'b0;
        r.cls = 4'd0;
      end
    endcase
    return r;
  endfunction

  // sharp and flat wrap within the octave
  function automatic cls_t apply_accidental(input logic [3:0] cls, input logic [7:0] acc);
    cls_t r;
    r.ok  = 1'b1;
    r.cls = cls;
    if (acc == ChSharp) begin
      r.cls = (cls == 4'd11) ? 4'd0 : cls + 4'd1;
    end else if (acc == ChFlat) begin
      r.cls = (cls == 4'd0) ? 4'd11 : cls - 4'd1;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [3:0] member_step(input kind_e kind, input logic [1:0] idx);
    logic [3:0] s;
    case (idx)
      2'd0:    s = 4'd0;
      2'd1:    s = (kind == KindSeventh || kind == KindMajor) ? 4'd4 : 4'd3;
      2'd2:    s = (kind == KindDim) ? 4'd6 : 4'd7;
      default: s = 4'd10;
    endcase
    return s;
  endfunction

  function automatic logic [1:0] last_member(input kind_e kind);
    return (kind == KindSeventh) ? 2'd3 : 2'd2;
  endfunction

endpackage

/* rtl/note_chord_command_parser.sv */
// note and chord command parser: collects text bytes, parses on the last byte
// and sends out one result per pitch; depends on ncp_pkg
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------------------
//  in       | in_valid_i / in_stall_o  | char_byte_i, end_of_text_i
//  out      | out_valid_o / out_stall_i| status_o, pitch_o, address_o, last_result_o
//  cfg      | cfg_we_i                 | cfg_wdata_i (bottom pitch)
//
// a byte is taken every valid cycle unless a final byte stalls; the final byte is parsed
// in the cycle it is taken and the parsed command is held in one command register
// a command gives one result per cycle unless the output stalls: one for a note or error,
// three or four for a chord; a final byte is stalled only while the previous command still
// has results to send, released in the cycle its last result is taken
// reset clears the length count, the pending flag, the member index and the bottom pitch

module note_chord_command_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_byte_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [6:0] pitch_o,
  output logic [6:0] address_o,
  output logic       last_result_o,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i
);

  import ncp_pkg::*;

  logic [7:0]          buf_q [MaxText];
  logic [LenWidth-1:0] len_q, len_d;
  logic [6:0]          bottom_q;
  cmd_t                cmd_q, cmd_d;
  logic                cmd_valid_q, cmd_valid_d;
  logic [1:0]          idx_q, idx_d;

  logic                in_fire, out_fire, out_done;
  logic [7:0]          v [MaxText];
  logic [LenWidth-1:0] n;
  cls_t                lc, ac;
  logic [7:0]          kch, dch;
  logic [6:0]          digit_x12;
  logic [6:0]          pitch_sum;
  logic                below;
  logic [1:0]          last_idx;

  assign out_valid_o = cmd_valid_q;
  assign out_fire    = out_valid_o && !out_stall_i;
  assign last_idx    = cmd_q.chord ? last_member(cmd_q.kind) : 2'd0;
  assign out_done    = out_fire && (cmd_q.err || idx_q == last_idx);
  assign in_stall_o  = end_of_text_i && cmd_valid_q && !out_done;
  assign in_fire     = in_valid_i && !in_stall_o;

  // text as it stands once the incoming byte is stored
  always_comb begin
    for (int i = 0; i < MaxText; i++) begin
      v[i] = (len_q == LenWidth'(i)) ? char_byte_i : buf_q[i];
    end
    n = (len_q < LenWidth'(MaxText)) ? len_q + 3'd1 : LenWidth'(MaxText + 1);
  end

  // parse
  always_comb begin
    cmd_d     = '0;
    cmd_d.err = 1'b1;
    lc        = '0;
    ac        = '0;
    kch       = v[2];
    dch       = v[1];
    digit_x12 = '0;
    if (n >= 3'd2 && n <= 3'd4) begin
      if (v[0] == ChChord) begin
        if (n >= 3'd3) begin
          lc     = letter_class(v[1]);
          ac     = apply_accidental(lc.cls, v[2]);
          kch    = (n == 3'd4) ? v[3] : v[2];
          cmd_d.chord = 1'b1;
          cmd_d.base  = {3'd0, (n == 3'd4) ? ac.cls : lc.cls};
          cmd_d.err   = !lc.ok || (n == 3'd4 && !ac.ok);
          case (kch)
            ChSev:   cmd_d.kind = KindSeventh;
            ChFive:  cmd_d.kind = KindMajor;
            ChMin:   cmd_d.kind = KindMinor;
            ChDim:   cmd_d.kind = KindDim;
            default: begin
              cmd_d.kind = KindSeventh;
              cmd_d.err  = 1'b1;
            end
          endcase
        end
      end else if (n <= 3'd3) begin
        lc        = letter_class(v[0]);
        ac        = apply_accidental(lc.cls, v[1]);
        dch       = (n == 3'd3) ? v[2] : v[1];
        // octave times twelve as eight plus four
        digit_x12 = {dch[3:0], 3'd0} + {1'd0, dch[3:0], 2'd0};
        cmd_d.base = digit_x12 + {3'd0, (n == 3'd3) ? ac.cls : lc.cls};
        cmd_d.err  = !lc.ok || (n == 3'd3 && !ac.ok) || !(dch inside {[ChZero:ChNine]});
      end
    end
  end

  // result fields
  always_comb begin
    pitch_sum     = cmd_q.base + {3'd0, member_step(cmd_q.kind, idx_q)};
    below         = pitch_sum < bottom_q;
    last_result_o = cmd_q.err || idx_q == last_idx;
    if (cmd_q.err) begin
      status_o  = StError;
      pitch_o   = '0;
      address_o = '0;
    end else if (below) begin
      status_o  = StBelow;
      pitch_o   = pitch_sum;
      address_o = '0;
    end else begin
      status_o  = cmd_q.chord ? StChord : StNote;
      pitch_o   = pitch_sum;
      address_o = pitch_sum - bottom_q;
    end
  end

  always_comb begin
    len_d       = len_q;
    cmd_valid_d = cmd_valid_q;
    idx_d       = idx_q;
    if (out_fire) begin
      idx_d = idx_q + 2'd1;
    end
    if (out_done) begin
      cmd_valid_d = 1'b0;
      idx_d       = '0;
    end
    if (in_fire) begin
      if (end_of_text_i) begin
        len_d       = '0;
        cmd_valid_d = 1'b1;
        idx_d       = '0;
      end else begin
        len_d = n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && len_q < LenWidth'(MaxText)) begin
      buf_q[len_q[1:0]] <= char_byte_i;
    end
    if (in_fire && end_of_text_i) begin
      cmd_q <= cmd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      cmd_valid_q <= 1'b0;
      idx_q       <= '0;
      bottom_q    <= '0;
    end else begin
      len_q       <= len_d;
      cmd_valid_q <= cmd_valid_d;
      idx_q       <= idx_d;
      if (cfg_we_i) begin
        bottom_q <= cfg_wdata_i;
      end
    end
  end

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StError |-> last_result_o)
    else $error("error result not marked last");

  a_final_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && end_of_text_i |=> out_valid_o)
    else $error("final byte taken but no result pending");

  a_chord_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_result_o |=> out_valid_o && status_o != StError)
    else $error("chord members cut short");

  a_below_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == StBelow || status_o == StError) |-> address_o == '0)
    else $error("address set on flagged result");

endmodule
